// ===== design/twms_pkg.sv =====
// Shared constants and types for the trimmed window median / sigma block.
// No dependencies; imported by the interfaces, the top level and the checker.
package twms_pkg;

  localparam int WINDOW_MAX = 32;
  localparam int SAMPLE_W   = 24;
  localparam int ADDR_W     = 5;          // index into the window
  localparam int CNT_W      = 6;          // counts up to WINDOW_MAX
  localparam int MED_W      = SAMPLE_W + 1;
  localparam int S1_W       = 30;         // signed sum of up to 32 samples
  localparam int SQ_W       = 2 * SAMPLE_W - 1;
  localparam int S2_W       = 52;
  localparam int NUM_W      = 57;         // n*S2 - S1^2
  localparam int DEN_W      = 10;         // n*(n-1)
  localparam int SQ_RT_W    = 58;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_HIGH   = 2'd2;

  localparam logic [CNT_W-1:0] WINDOW_RESET = 6'd16;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MERGE = 8'b0000_0010,
    ST_STATS = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_SUB   = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

endpackage

// ===== design/twms_if.sv =====
// Valid/ready channel interfaces for samples in and results out.
// Depends on twms_pkg.
interface twms_in_if import twms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface twms_out_if import twms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [MED_W-1:0]    median_half;
  logic        [SAMPLE_W-1:0] sigma;
  logic        [CNT_W-1:0]    fill_count;
  modport source (output valid, output median_half, output sigma, output fill_count,
                  input ready);
  modport sink   (input valid, input median_half, input sigma, input fill_count,
                  output ready);
endinterface

// ===== design/trimmed_window_median_sigma.sv =====
// Trimmed running median and standard deviation over a ring window.
// Depends on twms_pkg and the channel interfaces in twms_if.sv.
//
// Usage: samples come in on in_i, one result per sample leaves on out_o.
// The window lives in a ring memory; a second memory with two banks holds
// the sorted window. Per sample the block:
//   - writes the sample into the ring and reads the entry it evicts at the
//     accepting edge
//   - rebuilds the sorted list in the other bank, dropping the evicted value
//     and inserting the new one, at most one memory write a cycle
//   - walks the kept ranks for median, sum and sum of squares
//   - forms kept*S2-S1^2 and kept*(kept-1), divides one quotient bit a
//     cycle and takes the integer root two bits a cycle (29 steps and a
//     closing step)
// With fewer than two kept the divide and root are skipped. One sample is in
// flight at a time; in_i.ready is high while idle, also while a result waits
// in the output register. A stalled receiver holds the result; a finished
// next result waits until the output register is free.
// Reset: window_size 16, no trims, empty window. Writing window_size clears
// the window at once; no clearing pass is needed since only entries written
// since the clear are ever read.
module trimmed_window_median_sigma import twms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  twms_in_if.sink              in_i,
  twms_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  state_e state_q;

  logic [CNT_W-1:0]  size_q, tlo_q, thi_q, held_q;
  logic [ADDR_W-1:0] wp_q;
  logic              bank_q;

  // memories
  logic signed [SAMPLE_W-1:0] win_mem [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] win_rd_q;
  logic signed [SAMPLE_W-1:0] sort_mem [2*WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sort_rd_q;
  logic [ADDR_W:0]            sort_ra, sort_wa;
  logic                       sort_we;
  logic signed [SAMPLE_W-1:0] sort_wd;

  // per item
  logic signed [SAMPLE_W-1:0] new_q;
  logic [CNT_W-1:0] m_q, n_q, lo_q, hi_q, us_q, mid_q, r_q, w_q, k_q, p1_idx_q;
  logic             rm_pend_q, ins_q, p1_v_q, p2_v_q;
  logic signed [SAMPLE_W-1:0] ma_q, mb_q;
  logic signed [S1_W-1:0]     s1_q;
  logic [SQ_W-1:0]            sq_q;
  logic [S2_W-1:0]            s2_q;
  logic [NUM_W-1:0]           pa_q, quo_q;
  logic [NUM_W:0]             pb_q;
  logic [DEN_W-1:0]           den_q;
  logic [DEN_W:0]             rem_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [SQ_RT_W-1:0]         x_q, rt_q, bit_q;
  logic [SAMPLE_W-1:0]        sigma_q;

  logic                       out_valid_q;
  logic signed [MED_W-1:0]    out_med_q;
  logic [SAMPLE_W-1:0]        out_sig_q;
  logic [CNT_W-1:0]           out_fill_q;

  logic in_fire, out_fire;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.median_half = out_med_q;
  assign out_o.sigma       = out_sig_q;
  assign out_o.fill_count  = out_fill_q;

  // accept-time window bookkeeping
  logic             full;
  logic [CNT_W-1:0] n_next, lo_next, hi_next, us_next;
  logic [CNT_W:0]   wp_inc;
  always_comb begin
    full   = (held_q == size_q);
    n_next = full ? held_q : held_q + 6'd1;
    if (thi_q >= n_next || tlo_q >= n_next - thi_q) begin
      lo_next = '0;
      hi_next = n_next;
    end else begin
      lo_next = tlo_q;
      hi_next = n_next - thi_q;
    end
    us_next = hi_next - lo_next;
    wp_inc  = {1'b0, wp_q} + 7'd1;
  end

  // merge step decisions
  logic head_v, rm_hit, ins_now, consume, merge_done;
  always_comb begin
    head_v     = (r_q < m_q);
    rm_hit     = head_v && rm_pend_q && (sort_rd_q == win_rd_q);
    ins_now    = !ins_q && (!head_v || new_q <= sort_rd_q);
    merge_done = ins_q && !head_v;
    consume    = 1'b0;
    sort_we    = 1'b0;
    sort_wd    = sort_rd_q;
    if (state_q == ST_MERGE && !merge_done) begin
      if (rm_hit) begin
        consume = 1'b1;
      end else if (ins_now) begin
        sort_we = 1'b1;
        sort_wd = new_q;
      end else begin
        sort_we = 1'b1;
        consume = 1'b1;
      end
    end
  end

  logic [CNT_W-1:0] r_inc;
  assign r_inc   = r_q + 6'd1;
  assign sort_wa = {~bank_q, w_q[ADDR_W-1:0]};

  always_comb begin
    case (state_q)
      ST_MERGE: sort_ra = {bank_q, consume ? r_inc[ADDR_W-1:0] : r_q[ADDR_W-1:0]};
      ST_STATS: sort_ra = {bank_q, k_q[ADDR_W-1:0]};
      default:  sort_ra = {bank_q, {ADDR_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_rd_q        <= win_mem[wp_q];
      win_mem[wp_q]   <= in_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sort_we) sort_mem[sort_wa] <= sort_wd;
    sort_rd_q <= sort_mem[sort_ra];
  end

  // arithmetic helpers
  logic [S1_W-2:0]    mag;
  logic [DEN_W:0]     rem_sh;
  logic [SQ_RT_W-1:0] trial;
  logic [CNT_W-1:0]   p1_inc;
  logic               even;
  assign mag    = s1_q[S1_W-1] ? (S1_W-1)'(-s1_q) : s1_q[S1_W-2:0];
  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign trial  = rt_q + bit_q;
  assign p1_inc = p1_idx_q + 6'd1;
  assign even   = !us_q[0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= WINDOW_RESET;
      tlo_q       <= '0;
      thi_q       <= '0;
      held_q      <= '0;
      wp_q        <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      rm_pend_q   <= 1'b0;
      ins_q       <= 1'b0;
      r_q         <= '0;
      w_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_SIZE: begin
            if (cfg_data_i == '0) size_q <= 6'd1;
            else if (cfg_data_i > CNT_W'(WINDOW_MAX)) size_q <= CNT_W'(WINDOW_MAX);
            else size_q <= cfg_data_i;
            held_q <= '0;
            wp_q   <= '0;
          end
          REG_TRIM_LOW:  tlo_q <= cfg_data_i;
          REG_TRIM_HIGH: thi_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_FIN && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            held_q    <= n_next;
            wp_q      <= (wp_inc == {1'b0, size_q}) ? '0 : wp_inc[ADDR_W-1:0];
            rm_pend_q <= full;
            ins_q     <= 1'b0;
            r_q       <= '0;
            w_q       <= '0;
            state_q   <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (merge_done) begin
            bank_q  <= ~bank_q;
            k_q     <= lo_q;
            p1_v_q  <= 1'b0;
            p2_v_q  <= 1'b0;
            state_q <= ST_STATS;
          end else begin
            if (rm_hit) rm_pend_q <= 1'b0;
            else if (ins_now) ins_q <= 1'b1;
            if (consume) r_q <= r_inc;
            if (sort_we) w_q <= w_q + 6'd1;
          end
        end
        ST_STATS: begin
          p1_v_q <= (k_q < hi_q);
          p2_v_q <= p1_v_q;
          if (k_q < hi_q) k_q <= k_q + 6'd1;
          else if (!p1_v_q && !p2_v_q) state_q <= ST_MUL;
        end
        ST_MUL: state_q <= (us_q < 6'd2) ? ST_FIN : ST_SUB;
        ST_SUB: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == CNT_W'(NUM_W - 1)) state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (bit_q == '0) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          new_q <= in_i.sample;
          m_q   <= held_q;
          n_q   <= n_next;
          lo_q  <= lo_next;
          hi_q  <= hi_next;
          us_q  <= us_next;
          mid_q <= lo_next + (us_next >> 1);
          s1_q  <= '0;
          s2_q  <= '0;
        end
      end
      ST_STATS: begin
        p1_idx_q <= k_q;
        if (p1_v_q) begin
          s1_q <= s1_q + S1_W'(sort_rd_q);
          sq_q <= SQ_W'(sort_rd_q * sort_rd_q);
          if (p1_idx_q == mid_q) mb_q <= sort_rd_q;
          if (p1_inc == mid_q) ma_q <= sort_rd_q;
        end
        if (p2_v_q) s2_q <= s2_q + S2_W'(sq_q);
      end
      ST_MUL: begin
        pa_q    <= NUM_W'(s2_q * us_q);
        pb_q    <= mag * mag;
        den_q   <= DEN_W'(us_q * (us_q - 6'd1));
        sigma_q <= '0;
      end
      ST_SUB: begin
        quo_q <= pa_q - pb_q[NUM_W-1:0];
        rem_q <= '0;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          quo_q <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[NUM_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          // last quotient bit joins the root input directly
          x_q   <= {1'b0, quo_q[NUM_W-2:0], (rem_sh >= {1'b0, den_q})};
          rt_q  <= '0;
          bit_q <= SQ_RT_W'(1) << (NUM_W - 1);
        end
      end
      ST_SQRT: begin
        if (bit_q != '0) begin
          if (x_q >= trial) begin
            x_q  <= x_q - trial;
            rt_q <= (rt_q >> 1) + bit_q;
          end else begin
            rt_q <= rt_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          sigma_q <= (rt_q > SQ_RT_W'({SAMPLE_W{1'b1}})) ? {SAMPLE_W{1'b1}}
                                                          : rt_q[SAMPLE_W-1:0];
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_med_q  <= even ? (MED_W'(ma_q) + MED_W'(mb_q)) : (MED_W'(mb_q) <<< 1);
          out_sig_q  <= sigma_q;
          out_fill_q <= n_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/twms_checker.sv =====
// Port-level checks for trimmed_window_median_sigma, attached by bind.
// Depends on twms_pkg.
module twms_checker import twms_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CNT_W-1:0] fill_count_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(fill_count_i))
    else $error("fill count changed while stalled");

  // one sample in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while busy");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (fill_count_i != '0 && fill_count_i <= CNT_W'(WINDOW_MAX)))
    else $error("fill count out of range");

endmodule

bind trimmed_window_median_sigma twms_checker u_twms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .fill_count_i (out_o.fill_count)
);

// ===== verif/tb.sv =====
// Testbench for trimmed_window_median_sigma: directed table, then random traffic.
// Depends on twms_pkg, the channel interfaces in twms_if.sv and the top level.
`timescale 1ns / 1ps

module tb;
  import twms_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;   // past the register list
  localparam int DRAIN_CYCLES = 200;                    // above the block's latency
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 500;

  typedef struct packed {
    logic signed [MED_W-1:0]    median_half;
    logic        [SAMPLE_W-1:0] sigma;
    logic        [CNT_W-1:0]    fill_count;
  } result_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CNT_W-1:0]           data;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       typed;
    result_t                    want;
  } row_t;

  localparam int N_ROWS = 35;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd8388608, 1'b1, '{-25'sd16777216, 24'd0, 6'd1}},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd8388607, 1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd0,       1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd1,       1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd1,       1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd16,      1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd16,      1'b0, '0},
    '{ROW_CFG, REG_TRIM_LOW,  6'd3, 24'sd0,  1'b0, '0},
    '{ROW_CFG, REG_TRIM_HIGH, 6'd2, 24'sd0,  1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd100,     1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd200,     1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd300,     1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd400,     1'b0, '0},
    // trims larger than the fill: everything is kept
    '{ROW_CFG, REG_TRIM_LOW,  6'd32, 24'sd0, 1'b0, '0},
    '{ROW_CFG, REG_TRIM_HIGH, 6'd63, 24'sd0, 1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd5,       1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd5,       1'b0, '0},
    // oversize window saturates and clears
    '{ROW_CFG, REG_WINDOW_SIZE, 6'd63, 24'sd0, 1'b0, '0},
    '{ROW_CFG, REG_TRIM_LOW,  6'd0, 24'sd0,  1'b0, '0},
    '{ROW_CFG, REG_TRIM_HIGH, 6'd0, 24'sd0,  1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd8388607, 1'b1, '{25'sd16777214, 24'd0, 6'd1}},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd8388607, 1'b1, '{25'sd16777214, 24'd0, 6'd2}},
    // zero window is taken as one
    '{ROW_CFG, REG_WINDOW_SIZE, 6'd0, 24'sd0, 1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd8388608, 1'b1, '{-25'sd16777216, 24'd0, 6'd1}},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd12345,   1'b1, '{25'sd24690, 24'd0, 6'd1}},
    '{ROW_CFG, REG_UNUSED, 6'd63, 24'sd0,    1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd7,       1'b1, '{-25'sd14, 24'd0, 6'd1}},
    '{ROW_CFG, REG_WINDOW_SIZE, 6'd2, 24'sd0, 1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd1,       1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd2,       1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd3,       1'b0, '0},
    '{ROW_CFG, REG_WINDOW_SIZE, 6'd32, 24'sd0, 1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0, -24'sd4096,    1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd4096,    1'b0, '0},
    '{ROW_SAMPLE, 2'd0, 6'd0,  24'sd4095,    1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CNT_W-1:0]     cfg_data;

  twms_in_if  in_ch ();
  twms_out_if out_ch ();

  trimmed_window_median_sigma i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  longint     win_vals [WINDOW_MAX];
  int         wr_ptr;
  int         held;
  int         win_len;
  int         cut_low;
  int         cut_high;

  result_t    expected_results [$];
  int         errors;
  int         results_seen;
  int         cycles;
  int         send_idle_pct;
  int         rcv_idle_pct;
  bit         held_once;
  longint     level;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic void window_clear();
    foreach (win_vals[k]) win_vals[k] = 0;
    wr_ptr = 0;
    held   = 0;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] v);
    case (idx)
      REG_WINDOW_SIZE: begin
        win_len = (v == 0) ? 1 : (v > WINDOW_MAX) ? WINDOW_MAX : int'(v);
        window_clear();
      end
      REG_TRIM_LOW:  cut_low  = int'(v);
      REG_TRIM_HIGH: cut_high = int'(v);
      default: ;
    endcase
  endfunction

  function automatic result_t trimmed_stats(input logic signed [SAMPLE_W-1:0] s);
    longint            ord [WINDOW_MAX];
    longint            v;
    int                lo, hi, kept, j;
    longint unsigned   s1, s2, u, mag, num, den, var_q, root, bit_w;
    longint            med;
    result_t           r;
    win_vals[wr_ptr % WINDOW_MAX] = longint'(s);
    wr_ptr = (wr_ptr + 1) % win_len;
    if (held < win_len) held++;
    for (int i = 0; i < held; i++) begin
      v = win_vals[i];
      j = i;
      while (j > 0 && ord[j-1] > v) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    if (cut_high >= held || cut_low >= held - cut_high) begin
      lo = 0;
      hi = held;
    end else begin
      lo = cut_low;
      hi = held - cut_high;
    end
    kept = hi - lo;
    if (kept % 2) med = ord[lo + kept/2] * 2;
    else          med = ord[lo + kept/2 - 1] + ord[lo + kept/2];
    root = 0;
    if (kept >= 2) begin
      s1 = 0;
      s2 = 0;
      for (int i = lo; i < hi; i++) begin
        u  = longint'(ord[i]);
        s1 += u;
        s2 += u * u;
      end
      mag   = s1[63] ? (64'd0 - s1) : s1;
      num   = longint'(kept) * s2 - mag * mag;
      den   = longint'(kept) * longint'(kept - 1);
      var_q = num / den;
      // bitwise integer square root
      bit_w = 64'd1 << 62;
      while (bit_w > var_q) bit_w >>= 2;
      while (bit_w != 0) begin
        if (var_q >= root + bit_w) begin
          var_q -= root + bit_w;
          root = (root >> 1) + bit_w;
        end else begin
          root >>= 1;
        end
        bit_w >>= 2;
      end
      if (root > 64'hFF_FFFF) root = 64'hFF_FFFF;
    end
    r.median_half = med[MED_W-1:0];
    r.sigma       = root[SAMPLE_W-1:0];
    r.fill_count  = held[CNT_W-1:0];
    return r;
  endfunction

  // enter at a falling edge, leave at a falling edge with valid still high
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                             input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= SAMPLE_W'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = trimmed_stats(s);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    apply_cfg(idx, v);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    longint x;
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 24'sh7F_FFFF : 24'sh80_0000;
      1, 2:    return SAMPLE_W'($urandom);
      default: begin
        x = level + longint'($urandom_range(2000)) - 1000;
        if ($urandom_range(7) == 0) x += longint'($urandom_range(200000)) - 100000;
        if (x > 8388607)  x = 8388607;
        if (x < -8388608) x = -8388608;
        return x[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_trim();
    if ($urandom_range(5) == 0) return CNT_W'($urandom);
    return CNT_W'($urandom_range(4));
  endfunction

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    held_once    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_once && results_seen >= 150) begin
        // long hold-off so the block backs up into its input
        held_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result transfer, median_half", out_ch.median_half, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.median_half !== want.median_half)
          report("median_half", out_ch.median_half, want.median_half);
        if (out_ch.sigma !== want.sigma)
          report("sigma", out_ch.sigma, want.sigma);
        if (out_ch.fill_count !== want.fill_count)
          report("fill_count", out_ch.fill_count, want.fill_count);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    errors        = 0;
    results_seen  = 0;
    cycles        = 0;
    send_idle_pct = 35;
    rcv_idle_pct  = 68;
    level         = 0;
    win_len       = int'(WINDOW_RESET);
    cut_low       = 0;
    cut_high      = 0;
    window_clear();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) cfg_write(DIRECTED[r].idx, DIRECTED[r].data);
      else send_sample(DIRECTED[r].sample, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 68 : 0;
      rcv_idle_pct  = (mode == 0) ? 68 : (mode == 1) ? 35 : 0;
      for (int chunk = 0; chunk < 7; chunk++) begin
        cfg_write(REG_WINDOW_SIZE, ($urandom_range(3) == 0) ? CNT_W'($urandom)
                                                          : CNT_W'($urandom_range(1, 32)));
        cfg_write(REG_TRIM_LOW,  pick_trim());
        cfg_write(REG_TRIM_HIGH, pick_trim());
        level = longint'($urandom_range(16000000)) - 8000000;
        repeat (50) send_sample(pick_sample(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else             $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/twms_pkg.sv
design/twms_if.sv
design/trimmed_window_median_sigma.sv
design/twms_checker.sv
verif/tb.sv
